// ===== rtl/core/hb_pkg.sv =====
// shared types and constants for the histogram binning block
package hb_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

  localparam logic signed [31:0] RANGE_MIN_RST = 32'sd0;
  localparam logic [31:0] BIN_SCALE_RST = 32'd655360;
  localparam logic [7:0] BIN_COUNT_RST = 8'd10;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_READ_CLR = 2'd2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [31:0] sample;
    logic [6:0] bin_index;
  } hb_in_t;

  typedef struct packed {
    logic in_range;
    logic [6:0] bin_hit;
    logic [31:0] bin_value;
    logic [31:0] total_samples;
  } hb_out_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } hb_state_t;

endpackage

// ===== rtl/core/hb_ram.sv =====
// generic single write port ram with registered read
module hb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/histogram_binning.sv =====
// top level of the uniform bin histogram
//
// One beat is accepted at every rising edge with start high and busy low, so a new
// beat can enter in every cycle. Each beat gives exactly one result, shown on out_data
// for one cycle with out_valid high; the receiver cannot stall, so results must be
// taken as they come. The pipeline is: input register, a 33 bit subtract of
// range_min, a 32x32 multiply by bin_scale, bin index and range check with the bin
// ram read, then the read-modify-write of the count, then the output register. The
// bin counts live in a NUM_BINS deep ram with one write port; a one-deep forward
// path covers two beats in a row that touch the same bin. After reset the block
// holds busy high while it writes zero to every bin; configuration writes are taken
// at any time but should only be made while no beat is in flight.
module histogram_binning #(
  parameter int unsigned NUM_BINS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  hb_pkg::hb_in_t                     in_data,
  output logic                               out_valid,
  output hb_pkg::hb_out_t                    out_data,
  input  logic                               cfg_we,
  input  logic [hb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

  // configuration registers
  logic signed [31:0] range_min_r;
  logic [31:0]        bin_scale_r;
  logic [7:0]         bin_count_r;
  logic [7:0]         active_bins;

  // clearing sweep after reset
  hb_pkg::hb_state_t state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  // stage 1: input register
  logic           s1_valid_r;
  hb_pkg::hb_in_t s1_r;

  // stage 2: difference from the lower edge
  logic        s2_valid_r;
  logic [1:0]  s2_mode_r;
  logic [6:0]  s2_bin_index_r;
  logic        s2_neg_r;
  logic [31:0] s2_diff_r;
  logic signed [32:0] diff_nxt;

  // stage 3: scaled index
  logic        s3_valid_r;
  logic [1:0]  s3_mode_r;
  logic [6:0]  s3_bin_index_r;
  logic        s3_neg_r;
  logic [31:0] s3_q_r;
  logic [63:0] prod_nxt;

  // stage 4: read-modify-write
  logic          s4_valid_r;
  logic [1:0]    s4_mode_r;
  logic          s4_ok_r, s4_ok_nxt;
  logic [6:0]    s4_hit_r, s4_hit_nxt;
  logic [AW-1:0] s4_addr_r, s4_addr_nxt;
  logic [31:0]   q_eff;

  // ram and forwarding
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;
  logic          upd_we;
  logic [31:0]   upd_data;
  logic [31:0]   cur_count;
  logic          fw_valid_r;
  logic [AW-1:0] fw_addr_r;
  logic [31:0]   fw_data_r;

  // running total and result
  logic [31:0]     total_r, total_nxt;
  logic            out_valid_r;
  hb_pkg::hb_out_t out_r, out_nxt;

  // bins in use, capped at the store depth
  always_comb begin
    if (32'(bin_count_r) > 32'(NUM_BINS)) begin
      active_bins = 8'(NUM_BINS);
    end else begin
      active_bins = bin_count_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= hb_pkg::RANGE_MIN_RST;
      bin_scale_r <= hb_pkg::BIN_SCALE_RST;
      bin_count_r <= hb_pkg::BIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hb_pkg::CFG_RANGE_MIN: range_min_r <= cfg_wdata;
        hb_pkg::CFG_BIN_SCALE: bin_scale_r <= cfg_wdata;
        hb_pkg::CFG_BIN_COUNT: bin_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // clear sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hb_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      hb_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt    = hb_pkg::ST_RUN;
          clr_addr_nxt = '0;
        end
      end
      hb_pkg::ST_RUN: begin
        state_nxt = hb_pkg::ST_RUN;
      end
      default: begin
        state_nxt = hb_pkg::ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != hb_pkg::ST_RUN);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fw_valid_r  <= 1'b0;
      total_r     <= '0;
    end else begin
      s1_valid_r  <= start && !busy;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
      fw_valid_r  <= upd_we;
      total_r     <= total_nxt;
    end
  end

  // signed 33 bit difference, never wider than 32 bits when non-negative
  assign diff_nxt = {s1_r.sample[31], s1_r.sample} - {range_min_r[31], range_min_r};

  // 32x32 product, the integer part of the q32.32 value is the bin index
  assign prod_nxt = 64'(s2_diff_r) * 64'(bin_scale_r);

  // index check and ram address
  always_comb begin
    q_eff       = s3_neg_r ? 32'd0 : s3_q_r;
    s4_ok_nxt   = 1'b0;
    s4_hit_nxt  = '0;
    s4_addr_nxt = '0;
    case (s3_mode_r)
      hb_pkg::MODE_ADD: begin
        // below the lower edge only lands in bin 0 when the scale is zero
        if (!(s3_neg_r && (bin_scale_r != 32'd0)) && (q_eff < 32'(active_bins))) begin
          s4_ok_nxt   = 1'b1;
          s4_hit_nxt  = q_eff[6:0];
          s4_addr_nxt = q_eff[AW-1:0];
        end
      end
      hb_pkg::MODE_READ, hb_pkg::MODE_READ_CLR: begin
        s4_hit_nxt  = s3_bin_index_r;
        s4_addr_nxt = AW'(s3_bin_index_r);
        s4_ok_nxt   = (8'(s3_bin_index_r) < active_bins);
      end
      default: ;
    endcase
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_r <= in_data;
    end
    s2_mode_r      <= s1_r.mode;
    s2_bin_index_r <= s1_r.bin_index;
    s2_neg_r       <= diff_nxt[32];
    s2_diff_r      <= diff_nxt[31:0];
    s3_mode_r      <= s2_mode_r;
    s3_bin_index_r <= s2_bin_index_r;
    s3_neg_r       <= s2_neg_r;
    s3_q_r         <= prod_nxt[63:32];
    s4_mode_r      <= s3_mode_r;
    s4_ok_r        <= s4_ok_nxt;
    s4_hit_r       <= s4_hit_nxt;
    s4_addr_r      <= s4_addr_nxt;
    fw_addr_r      <= ram_waddr;
    fw_data_r      <= ram_wdata;
    out_r          <= out_nxt;
  end

  // count update with forwarding of the write made at the read edge
  always_comb begin
    if (fw_valid_r && (fw_addr_r == s4_addr_r)) begin
      cur_count = fw_data_r;
    end else begin
      cur_count = ram_rdata;
    end

    upd_we    = 1'b0;
    upd_data  = '0;
    total_nxt = total_r;
    out_nxt   = '0;

    if (s4_valid_r) begin
      out_nxt.in_range = s4_ok_r;
      out_nxt.bin_hit  = s4_hit_r;
      case (s4_mode_r)
        hb_pkg::MODE_ADD: begin
          if (total_r != hb_pkg::COUNT_MAX) begin
            total_nxt = total_r + 32'd1;
          end
          if (s4_ok_r) begin
            upd_we   = 1'b1;
            upd_data = (cur_count != hb_pkg::COUNT_MAX) ? cur_count + 32'd1 : cur_count;
            out_nxt.bin_value = upd_data;
          end
        end
        hb_pkg::MODE_READ: begin
          if (s4_ok_r) begin
            out_nxt.bin_value = cur_count;
          end
        end
        hb_pkg::MODE_READ_CLR: begin
          if (s4_ok_r) begin
            upd_we            = 1'b1;
            upd_data          = '0;
            out_nxt.bin_value = cur_count;
          end
        end
        default: ;
      endcase
      out_nxt.total_samples = total_nxt;
    end
  end

  // clearing sweep owns the write port until it ends
  always_comb begin
    if (busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s4_addr_r;
      ram_wdata = upd_data;
    end
  end

  hb_ram #(
    .WIDTH (32),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s4_addr_nxt),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/hb_checker.sv =====
// port level checks for the histogram binning block and its bind
module hb_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input hb_pkg::hb_out_t out_data
);

  // reset starts the clearing sweep
  assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised after reset");

  // every accepted beat gives a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result missing five cycles after accept");

  // no result without an accepted beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without accepted beat");

  // running total never goes down between results
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |->
      (out_data.total_samples >= $past(out_data.total_samples)))
    else $error("sample total decreased");

  // a miss carries no count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_range) |-> (out_data.bin_value == 32'd0))
    else $error("bin value on a miss");

endmodule

bind histogram_binning hb_checker u_hb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
